// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/psst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psst_pkg;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SINGLE = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;

	localparam logic [1:0] RUN_FULL   = 2'd3;
	localparam logic [1:0] BLANK_MAX  = 2'd3;
	localparam logic [1:0] BLANK_KEEP = 2'd2;

	// Result of the filter for the item held in the input register.
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic [7:0] last;
	} emit_t;

endpackage

`default_nettype wire

// ----- sv/psst_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psst_filter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     char_s1,
	output psst_pkg::emit_t     res
);

	typedef struct packed {
		logic       in_comment;
		logic [1:0] dkind;
		logic       s_open;
		logic [1:0] s_run;
		logic       d_open;
		logic [1:0] d_run;
		logic       esc;
		logic       skip;
		logic [1:0] blank;
		logic [7:0] last;
		logic [7:0] prev;
	} st_t;

	typedef struct packed {
		logic       own_open;
		logic [1:0] own_run;
		logic       other_open;
		logic [1:0] dkind;
		logic       skip;
	} qs_t;

	st_t st_q;
	st_t nx;
	logic emit;
	qs_t qs;

	function automatic qs_t quote_seen(
		input logic       own_open,
		input logic [1:0] own_run,
		input logic       other_open,
		input logic       prev_match,
		input logic [1:0] kind,
		input logic [1:0] dk,
		input logic       esc,
		input logic       incom
	);
		qs_t r;
		r.own_open   = own_open;
		r.own_run    = own_run;
		r.other_open = other_open;
		r.dkind      = dk;
		r.skip       = 1'b0;
		if (dk != psst_pkg::KIND_NONE) begin
			if (own_run == psst_pkg::RUN_FULL)
				r.own_run = 2'd2;
			else if (prev_match)
				r.own_run = own_run - 2'd1;
			else
				r.own_run = psst_pkg::RUN_FULL;
			r.dkind = (r.own_run != 2'd0) ? kind : psst_pkg::KIND_NONE;
			if (r.dkind == psst_pkg::KIND_NONE)
				r.skip = 1'b1;
		end else begin
			if (own_run == 2'd0 && !(own_open || other_open))
				r.own_run = 2'd1;
			else if (prev_match)
				r.own_run = own_run + 2'd1;
			r.dkind = (r.own_run == psst_pkg::RUN_FULL) ? kind : psst_pkg::KIND_NONE;
			if (r.dkind != psst_pkg::KIND_NONE) begin
				r.own_open   = 1'b0;
				r.other_open = 1'b0;
				r.skip       = 1'b1;
			end else if (!other_open && !incom) begin
				if (own_open) begin
					if (!esc) begin
						r.own_open = 1'b0;
						r.skip     = 1'b1;
					end
				end else begin
					r.own_open = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		nx   = st_q;
		emit = 1'b0;
		qs   = '0;
		if (!st_q.in_comment && !(st_q.s_open || st_q.d_open || st_q.dkind != psst_pkg::KIND_NONE)
			&& !st_q.esc && char_s1 == psst_pkg::CH_HASH) begin
			nx.in_comment = 1'b1;
			nx.blank      = 2'd0;
			nx.prev       = char_s1;
		end else if (st_q.in_comment && char_s1 != psst_pkg::CH_NL) begin
			nx.prev = char_s1;
		end else begin
			case (char_s1)
				psst_pkg::CH_NL: begin
					if (st_q.last == psst_pkg::CH_NL)
						nx.skip = 1'b1;
					nx.in_comment = 1'b0;
					nx.blank      = 2'd0;
				end
				psst_pkg::CH_DQUOTE: begin
					if (st_q.dkind != psst_pkg::KIND_SINGLE) begin
						qs = quote_seen(st_q.d_open, st_q.d_run, st_q.s_open,
							st_q.prev == psst_pkg::CH_DQUOTE, psst_pkg::KIND_DOUBLE,
							st_q.dkind, st_q.esc, st_q.in_comment);
						nx.d_open = qs.own_open;
						nx.d_run  = qs.own_run;
						nx.s_open = qs.other_open;
						nx.dkind  = qs.dkind;
						nx.skip   = st_q.skip | qs.skip;
					end
					nx.blank = 2'd0;
				end
				psst_pkg::CH_SQUOTE: begin
					if (st_q.dkind != psst_pkg::KIND_DOUBLE) begin
						qs = quote_seen(st_q.s_open, st_q.s_run, st_q.d_open,
							st_q.prev == psst_pkg::CH_SQUOTE, psst_pkg::KIND_SINGLE,
							st_q.dkind, st_q.esc, st_q.in_comment);
						nx.s_open = qs.own_open;
						nx.s_run  = qs.own_run;
						nx.d_open = qs.other_open;
						nx.dkind  = qs.dkind;
						nx.skip   = st_q.skip | qs.skip;
					end
					nx.blank = 2'd0;
				end
				psst_pkg::CH_TAB, psst_pkg::CH_SPACE: begin
					if (st_q.last == psst_pkg::CH_NL)
						nx.skip = 1'b1;
					else if (st_q.blank < psst_pkg::BLANK_MAX)
						nx.blank = st_q.blank + 2'd1;
				end
				default: nx.blank = 2'd0;
			endcase

			// Pin or clear the run counters against the docstring state.
			if (nx.dkind == psst_pkg::KIND_SINGLE) begin
				if (nx.s_run < psst_pkg::RUN_FULL && char_s1 != psst_pkg::CH_SQUOTE)
					nx.s_run = psst_pkg::RUN_FULL;
				nx.d_run = 2'd0;
			end else if (nx.dkind == psst_pkg::KIND_DOUBLE) begin
				if (nx.d_run < psst_pkg::RUN_FULL && char_s1 != psst_pkg::CH_DQUOTE)
					nx.d_run = psst_pkg::RUN_FULL;
				nx.s_run = 2'd0;
			end else if (nx.dkind == psst_pkg::KIND_NONE) begin
				if (char_s1 != psst_pkg::CH_SQUOTE)
					nx.s_run = 2'd0;
				if (char_s1 != psst_pkg::CH_DQUOTE)
					nx.d_run = 2'd0;
			end

			if (nx.skip) begin
				nx.skip = 1'b0;
			end else if (!(nx.s_open || nx.d_open || nx.dkind != psst_pkg::KIND_NONE)
				&& nx.blank < psst_pkg::BLANK_KEEP) begin
				emit    = 1'b1;
				nx.last = char_s1;
			end

			nx.esc  = (char_s1 == psst_pkg::CH_BSLASH) ? ~st_q.esc : 1'b0;
			nx.prev = char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{last: psst_pkg::CH_SPACE, default: '0};
		end else if (step) begin
			st_q <= nx;
		end
	end

	assign res.emit = emit;
	assign res.data = char_s1;
	assign res.last = st_q.last;

endmodule

`default_nettype wire

// ----- sv/psst_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psst_out_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [7:0] data,
	input  wire logic       ready,
	output logic            can_load,
	output logic            valid,
	output logic [7:0]      q
);

	logic       valid_q;
	logic [7:0] data_q;

	assign can_load = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load)
			data_q <= data;
	end

	assign valid = valid_q;
	assign q     = data_q;

endmodule

`default_nettype wire

// ----- sv/python_comment_string_stripper_top.sv -----
//  channel   | payload        | handshake
//  ----------+----------------+------------------------------------
//  char_in   | char_in[7:0]   | char_in_valid / char_in_ready
//  char_out  | char_out[7:0]  | char_out_valid / char_out_ready
//
//  One item per cycle sustained unless char_out stalls; a kept byte passes from the
//  input register to the output register. The filter state is updated in one pass of
//  flag logic per item. Reset clears all flags, last emitted byte to space, previous
//  byte to zero. A stalled output holds its byte; an empty input register still takes
//  one more item, then char_in_ready drops until char_out_ready returns.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module python_comment_string_stripper_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_in_valid,
	output logic            char_in_ready,
	input  wire logic [7:0] char_in,
	output logic            char_out_valid,
	input  wire logic       char_out_ready,
	output logic [7:0]      char_out
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            can_load;
	logic            advance;
	psst_pkg::emit_t res;

	// The held item is processed in the cycle the output side can take its result.
	assign advance       = valid_s1 && can_load;
	assign char_in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in_ready) begin
			valid_s1 <= char_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in_valid && char_in_ready)
			char_s1 <= char_in;
	end

	psst_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_s1 (char_s1),
		.res     (res)
	);

	psst_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.emit),
		.data     (res.data),
		.ready    (char_out_ready),
		.can_load (can_load),
		.valid    (char_out_valid),
		.q        (char_out)
	);

	`ASSERT_NEXT(a_held_item_stays, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(char_s1))
	`ASSERT_NEXT(a_out_matches_last, clk, arst_n, advance && res.emit, char_out == res.last)
	`ASSERT_IMPLIES(a_out_from_step, clk, arst_n, $rose(char_out_valid), $past(advance && res.emit))
	`ASSERT_NEXT(a_no_emit_no_out, clk, arst_n, can_load && !(advance && res.emit), !char_out_valid)

endmodule

`default_nettype wire

// ----- test/python_comment_string_stripper_top_tb.sv -----
`timescale 1ns / 1ps

module python_comment_string_stripper_top_tb;

	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] gap;
		logic       drain;
	} src_item_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_SHORT
	} rx_mode_t;

	localparam int NUM_ITEMS   = 975;
	localparam int HOLD_CYCLES = 120;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       char_in_valid  = 1'b0;
	logic       char_in_ready;
	logic [7:0] char_in        = 8'h00;
	logic       char_out_valid;
	logic       char_out_ready = 1'b0;
	logic [7:0] char_out;

	python_comment_string_stripper_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_in_valid (char_in_valid),
		.char_in_ready (char_in_ready),
		.char_in       (char_in),
		.char_out_valid(char_out_valid),
		.char_out_ready(char_out_ready),
		.char_out      (char_out)
	);

	// Filter state mirrored from the block, at reset values.
	logic       cm_active    = 1'b0;
	logic [1:0] doc_kind     = psst_pkg::KIND_NONE;
	logic       sq_open      = 1'b0;
	logic [1:0] sq_run       = 2'd0;
	logic       dq_open      = 1'b0;
	logic [1:0] dq_run       = 2'd0;
	logic       esc_odd      = 1'b0;
	logic       skip_pending = 1'b0;
	logic [1:0] blank_cnt    = 2'd0;
	logic [7:0] last_kept    = psst_pkg::CH_SPACE;
	logic [7:0] prev_char    = 8'h00;

	src_item_t  pending_q[$];
	logic [7:0] kept_q[$];

	logic       in_taken  = 1'b0;
	logic       out_taken = 1'b0;
	logic [7:0] exp_char;
	src_item_t  next_item;
	int         gap_left    = 0;
	int         stall_left  = 0;
	int         hold_left   = 0;
	rx_mode_t   rx_mode     = RX_RANDOM;
	logic       tx_burst    = 1'b0;
	logic       drain_next  = 1'b0;
	int         added_cnt   = 0;
	int         bytes_in    = 0;
	int         kept_cnt    = 0;
	int         err_cnt     = 0;
	int         comment_cnt = 0;
	int         doc_cnt     = 0;
	int         hold_cnt    = 0;
	int         drain_cnt   = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		#0.5 arst_n = 1'b1;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic bit in_quotes();
		return sq_open || dq_open || doc_kind != psst_pkg::KIND_NONE;
	endfunction

	// Advance the filter by one byte; return 1 when the byte is kept.
	function automatic bit strip_byte(input logic [7:0] c);
		logic       own_open;
		logic       oth_open;
		logic [1:0] own_run;
		logic [1:0] kind;
		bit         keep;
		keep = 1'b0;
		if (!cm_active && !in_quotes() && !esc_odd && c == psst_pkg::CH_HASH) begin
			cm_active = 1'b1;
			blank_cnt = 2'd0;
			prev_char = c;
			comment_cnt++;
			return 1'b0;
		end
		// Comment bodies only move the previous byte.
		if (cm_active && c != psst_pkg::CH_NL) begin
			prev_char = c;
			return 1'b0;
		end

		case (c)
			psst_pkg::CH_NL: begin
				if (last_kept == psst_pkg::CH_NL)
					skip_pending = 1'b1;
				cm_active = 1'b0;
				blank_cnt = 2'd0;
			end
			psst_pkg::CH_DQUOTE, psst_pkg::CH_SQUOTE: begin
				if ((c == psst_pkg::CH_DQUOTE && doc_kind != psst_pkg::KIND_SINGLE) ||
				    (c == psst_pkg::CH_SQUOTE && doc_kind != psst_pkg::KIND_DOUBLE)) begin
					if (c == psst_pkg::CH_DQUOTE) begin
						own_open = dq_open;
						own_run  = dq_run;
						oth_open = sq_open;
						kind     = psst_pkg::KIND_DOUBLE;
					end else begin
						own_open = sq_open;
						own_run  = sq_run;
						oth_open = dq_open;
						kind     = psst_pkg::KIND_SINGLE;
					end
					if (doc_kind != psst_pkg::KIND_NONE) begin
						// Count the closing run back down.
						if (own_run == psst_pkg::RUN_FULL)
							own_run = 2'd2;
						else if (prev_char == c)
							own_run = own_run - 2'd1;
						else
							own_run = psst_pkg::RUN_FULL;
						doc_kind = (own_run != 2'd0) ? kind : psst_pkg::KIND_NONE;
						if (doc_kind == psst_pkg::KIND_NONE)
							skip_pending = 1'b1;
					end else begin
						if (own_run == 2'd0 && !(own_open || oth_open))
							own_run = 2'd1;
						else if (prev_char == c)
							own_run = own_run + 2'd1;
						doc_kind = (own_run == psst_pkg::RUN_FULL) ? kind : psst_pkg::KIND_NONE;
						if (doc_kind != psst_pkg::KIND_NONE) begin
							own_open     = 1'b0;
							oth_open     = 1'b0;
							skip_pending = 1'b1;
							doc_cnt++;
						end else if (!oth_open && !cm_active) begin
							if (own_open) begin
								if (!esc_odd) begin
									own_open     = 1'b0;
									skip_pending = 1'b1;
								end
							end else begin
								own_open = 1'b1;
							end
						end
					end
					if (c == psst_pkg::CH_DQUOTE) begin
						dq_open = own_open;
						dq_run  = own_run;
						sq_open = oth_open;
					end else begin
						sq_open = own_open;
						sq_run  = own_run;
						dq_open = oth_open;
					end
				end
				blank_cnt = 2'd0;
			end
			psst_pkg::CH_TAB, psst_pkg::CH_SPACE: begin
				if (last_kept == psst_pkg::CH_NL)
					skip_pending = 1'b1;
				else if (blank_cnt < psst_pkg::BLANK_MAX)
					blank_cnt = blank_cnt + 2'd1;
			end
			default: blank_cnt = 2'd0;
		endcase

		if (doc_kind == psst_pkg::KIND_SINGLE) begin
			if (sq_run < psst_pkg::RUN_FULL && c != psst_pkg::CH_SQUOTE)
				sq_run = psst_pkg::RUN_FULL;
			dq_run = 2'd0;
		end else if (doc_kind == psst_pkg::KIND_DOUBLE) begin
			if (dq_run < psst_pkg::RUN_FULL && c != psst_pkg::CH_DQUOTE)
				dq_run = psst_pkg::RUN_FULL;
			sq_run = 2'd0;
		end else if (doc_kind == psst_pkg::KIND_NONE) begin
			if (sq_run != 2'd0 && c != psst_pkg::CH_SQUOTE)
				sq_run = 2'd0;
			if (dq_run != 2'd0 && c != psst_pkg::CH_DQUOTE)
				dq_run = 2'd0;
		end

		if (skip_pending) begin
			skip_pending = 1'b0;
		end else if (!in_quotes() && blank_cnt < psst_pkg::BLANK_KEEP) begin
			keep      = 1'b1;
			last_kept = c;
		end
		esc_odd   = (c == psst_pkg::CH_BSLASH) ? !esc_odd : 1'b0;
		prev_char = c;
		return keep;
	endfunction

	task automatic add_byte(input logic [7:0] c);
		src_item_t it;
		it.ch    = c;
		it.gap   = tx_burst ? 5'd0 : 5'($urandom_range(0, 17));
		it.drain = drain_next;
		drain_next = 1'b0;
		pending_q.push_back(it);
		added_cnt++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'h41, 8'h5A));
			1: return 8'($urandom_range(8'h30, 8'h39));
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	// Byte inside a string or docstring quoted by q.
	function automatic logic [7:0] text_char(input logic [7:0] q);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return word_char();
		else if (sel < 14)
			return psst_pkg::CH_SPACE;
		else if (sel == 14)
			return psst_pkg::CH_NL;
		else if (sel == 15)
			return (q == psst_pkg::CH_SQUOTE) ? psst_pkg::CH_DQUOTE : psst_pkg::CH_SQUOTE;
		else if (sel == 16)
			return psst_pkg::CH_HASH;
		else if (sel == 17)
			return psst_pkg::CH_BSLASH;
		else if (sel == 18)
			return q;
		else
			return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic add_fragment();
		int         sel;
		int         n;
		logic [7:0] q;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		n   = $urandom_range(1, 6);
		q   = $urandom_range(0, 1) ? psst_pkg::CH_SQUOTE : psst_pkg::CH_DQUOTE;
		if (sel < 25) begin
			repeat (n) add_byte(word_char());
		end else if (sel < 37) begin
			repeat (n) add_byte($urandom_range(0, 3) == 0 ? psst_pkg::CH_TAB : psst_pkg::CH_SPACE);
		end else if (sel < 47) begin
			add_byte(psst_pkg::CH_NL);
			if ($urandom_range(0, 2) == 0)
				add_byte(psst_pkg::CH_NL);
			repeat ($urandom_range(0, 4)) add_byte(psst_pkg::CH_SPACE);
		end else if (sel < 61) begin
			add_byte(q);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0) begin
					add_byte(psst_pkg::CH_BSLASH);
					add_byte(q);
				end else begin
					add_byte(text_char(q));
				end
			end
			add_byte(q);
		end else if (sel < 72) begin
			repeat (3) add_byte(q);
			repeat ($urandom_range(0, 10)) add_byte(text_char(q));
			repeat (3) add_byte(q);
		end else if (sel < 82) begin
			add_byte(psst_pkg::CH_HASH);
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(0, 255));
				add_byte(c == psst_pkg::CH_NL ? psst_pkg::CH_SPACE : c);
			end
			add_byte(psst_pkg::CH_NL);
		end else if (sel < 88) begin
			repeat ($urandom_range(1, 3)) add_byte(psst_pkg::CH_BSLASH);
			case ($urandom_range(0, 2))
				0: add_byte(q);
				1: add_byte(psst_pkg::CH_HASH);
				default: add_byte(word_char());
			endcase
		end else if (sel < 94) begin
			// unbalanced quote runs
			repeat ($urandom_range(1, 5)) add_byte(q);
		end else begin
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Sender: hold the item until taken, then wait its gap.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_in_valid <= 1'b0;
			char_in       <= 8'h00;
			gap_left      = 0;
		end else begin
			logic       nxt_valid;
			logic [7:0] nxt_char;
			nxt_valid = char_in_valid;
			nxt_char  = char_in;
			if (char_in_valid && in_taken)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() != 0 &&
				             !(pending_q[0].drain && kept_q.size() != 0)) begin
					next_item = pending_q.pop_front();
					if (next_item.drain)
						drain_cnt++;
					nxt_valid = 1'b1;
					nxt_char  = next_item.ch;
					gap_left  = next_item.gap;
				end
			end
			char_in_valid <= nxt_valid;
			char_in       <= nxt_char;
		end
	end

	// Receiver: random stall, possibly none, after each item, with a long hold at 100 and 350 kept bytes.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_out_ready <= 1'b0;
			stall_left     = 0;
			hold_left      = 0;
		end else begin
			if (out_taken) begin
				if (kept_cnt % 64 == 0)
					rx_mode = rx_mode_t'($urandom_range(0, 2));
				if (kept_cnt == 100 || kept_cnt == 350) begin
					hold_left = HOLD_CYCLES;
					hold_cnt++;
				end
				case (rx_mode)
					RX_FREE:   stall_left = 0;
					RX_RANDOM: stall_left = $urandom_range(0, 17);
					default:   stall_left = $urandom_range(0, 3);
				endcase
			end
			if (hold_left > 0) begin
				hold_left--;
				char_out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				char_out_ready <= 1'b0;
			end else begin
				char_out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		in_taken  <= arst_n && char_in_valid && char_in_ready;
		out_taken <= arst_n && char_out_valid && char_out_ready;
		if (arst_n) begin
			if (char_out_valid && char_out_ready) begin
				kept_cnt++;
				if (kept_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte 0x%02h", char_out));
				end else begin
					exp_char = kept_q.pop_front();
					if (char_out !== exp_char)
						report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
							char_out, exp_char));
				end
			end
			if (char_in_valid && char_in_ready) begin
				bytes_in++;
				if (strip_byte(char_in))
					kept_q.push_back(char_in);
			end
		end
	end

	initial begin
		int next_phase;
		// directed: byte extremes, blanks, comment, docstring, escaped quote, blank lines
		add_byte(8'h00);
		add_text("  x\t#c\n\"\"\"d\"\"\"'\\'z\n\n");
		add_byte(8'hFF);
		next_phase = added_cnt;
		while (added_cnt < NUM_ITEMS) begin
			if (added_cnt >= next_phase) begin
				tx_burst   = ($urandom_range(0, 2) == 0);
				drain_next = 1'b1;
				next_phase = added_cnt + $urandom_range(80, 200);
			end
			add_fragment();
		end

		do @(negedge clk);
		while (pending_q.size() != 0 || char_in_valid || kept_q.size() != 0);
		repeat (20) @(negedge clk);

		$display("run: %0d source bytes in, %0d kept, %0d comments, %0d docstrings",
			bytes_in, kept_cnt, comment_cnt, doc_cnt);
		$display("run: %0d long output holds, %0d drain pauses, %0d mismatches",
			hold_cnt, drain_cnt, err_cnt);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
